// ===== sv/csvt_pkg.sv =====
// csvt_pkg: shared types and codes for the CSV byte tokenizer.
// Used by csvt_decode, csvt_outq and csv_byte_tokenizer_core; no dependencies.
package csvt_pkg;

  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic [1:0] CLS_NEWLINE = 2'd0;
  localparam logic [1:0] CLS_COMMA   = 2'd1;
  localparam logic [1:0] CLS_QUOTE   = 2'd2;
  localparam logic [1:0] CLS_OTHER   = 2'd3;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_FIELD = 2'd1;
  localparam logic [1:0] KIND_ROW   = 2'd2;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

// ===== sv/csv_byte_tokenizer_core.sv =====
// csv_byte_tokenizer_core: top level of the streaming CSV byte tokenizer.
// Depends on csvt_pkg, csvt_decode and csvt_outq.
//
//   channel | ports                                   | direction
//   input   | in_valid, in_stall, in_byte             | byte in
//   result  | out_valid, out_stall, out_kind/value/last | token out
//
// One byte is taken per cycle while in_stall is low; its results land in a
// four-entry queue the next cycle. An escaped byte (apostrophe, backslash)
// makes two results while the queue drains one per unstalled cycle, so each
// adds a result of backlog; once three wait, in_stall holds input until two.
// rst_n is synchronous and clears the tokenizer state and the queue.
// in_stall depends only on queue fill; out_stall holds the queue head.
module csv_byte_tokenizer_core import csvt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_value,
  output logic       out_last
);

  push_t push;
  res_t  head;
  logic  room2;
  logic  acc;

  assign in_stall = !room2;
  assign acc      = in_valid && room2;

  csvt_decode u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_byte (in_byte),
    .push    (push)
  );

  csvt_outq u_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room2     (room2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (head)
  );

  assign out_kind  = head.kind;
  assign out_value = head.value;
  assign out_last  = head.last;

endmodule

// ===== sv/csvt_decode.sv =====
// csvt_decode: tokenizer state registers and per-byte decode into up to two results.
// Depends on csvt_pkg.
module csvt_decode import csvt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] in_byte,
  output push_t      push
);

  logic [1:0] last_class_r, last_class_nxt;
  logic       parity_r, parity_nxt;
  logic       qact_r, qact_nxt;
  logic       empty_r, empty_nxt;

  always_comb begin
    last_class_nxt = last_class_r;
    parity_nxt     = parity_r;
    qact_nxt       = qact_r;
    empty_nxt      = empty_r;
    push           = '0;
    if (in_byte == CH_COMMA) begin
      if (parity_r && qact_r) begin
        push.n    = 2'd1;
        push.r0   = '{kind: KIND_DATA, value: in_byte, last: 1'b1};
        empty_nxt = 1'b0;
      end else begin
        qact_nxt   = 1'b0;
        parity_nxt = 1'b0;
        empty_nxt  = 1'b1;
        push.n     = 2'd1;
        push.r0    = '{kind: KIND_FIELD, value: 8'd0, last: 1'b1};
      end
      last_class_nxt = CLS_COMMA;
    end else if (in_byte == CH_QUOTE) begin
      last_class_nxt = CLS_QUOTE;
      if (!qact_r && (empty_r || last_class_r == CLS_COMMA)) begin
        parity_nxt = ~parity_r;
        qact_nxt   = 1'b1;
      end else if (last_class_r == CLS_QUOTE && !parity_r) begin
        parity_nxt = 1'b1;
        push.n     = 2'd1;
        push.r0    = '{kind: KIND_DATA, value: in_byte, last: 1'b1};
        empty_nxt  = 1'b0;
      end else begin
        parity_nxt = ~parity_r;
      end
    end else if (in_byte == CH_LF || in_byte == CH_CR) begin
      if (last_class_r != CLS_NEWLINE) begin
        parity_nxt     = 1'b0;
        empty_nxt      = 1'b1;
        last_class_nxt = CLS_NEWLINE;
        push.n         = 2'd1;
        push.r0        = '{kind: KIND_ROW, value: 8'd0, last: 1'b1};
      end
    end else begin
      if (in_byte == CH_APOS || in_byte == CH_BSLASH) begin
        push.n  = 2'd2;
        push.r0 = '{kind: KIND_DATA, value: CH_BSLASH, last: 1'b0};
        push.r1 = '{kind: KIND_DATA, value: in_byte, last: 1'b1};
      end else begin
        push.n  = 2'd1;
        push.r0 = '{kind: KIND_DATA, value: in_byte, last: 1'b1};
      end
      empty_nxt      = 1'b0;
      last_class_nxt = CLS_OTHER;
    end
    if (!acc) begin
      push.n = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_class_r <= CLS_NEWLINE;
      parity_r     <= 1'b0;
      qact_r       <= 1'b0;
      empty_r      <= 1'b1;
    end else if (acc) begin
      last_class_r <= last_class_nxt;
      parity_r     <= parity_nxt;
      qact_r       <= qact_nxt;
      empty_r      <= empty_nxt;
    end
  end

endmodule

// ===== sv/csvt_outq.sv =====
// csvt_outq: small result queue taking up to two results per cycle, one out per cycle unless stalled.
// Depends on csvt_pkg.
module csvt_outq import csvt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room2,
  output logic  out_valid,
  input  logic  out_stall,
  output res_t  out_res
);

  res_t           q_r [QDEPTH];
  logic [QAW-1:0] wr_r, wr_nxt;
  logic [QAW-1:0] rd_r, rd_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           pop;
  logic [QAW-1:0] wr1;

  assign out_valid = (cnt_r != '0);
  assign out_res   = q_r[rd_r];
  assign room2     = (cnt_r <= (QAW+1)'(QDEPTH - 2));
  assign pop       = out_valid && !out_stall;
  assign wr1       = wr_r + QAW'(1);

  always_comb begin
    wr_nxt  = wr_r + QAW'(push.n);
    rd_nxt  = rd_r + QAW'(pop);
    cnt_nxt = cnt_r + (QAW+1)'(push.n) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      q_r[wr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      q_r[wr1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAW+1)'(QDEPTH))
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> room2)
    else $error("push into result queue without room");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    QAW'(wr_r - rd_r) == cnt_r[QAW-1:0])
    else $error("queue pointers disagree with count");

endmodule

// ===== tb/sv/tb_csv_byte_tokenizer_core.sv =====
// tb_csv_byte_tokenizer_core: self-checking bench for the CSV byte tokenizer.
// Directed byte table, then random CSV rows and noise under three idling mixes.
// Depends on csvt_pkg and csv_byte_tokenizer_core.
module tb_csv_byte_tokenizer_core;
  import csvt_pkg::*;

  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } byte_step_t;

  localparam res_t NO_RES = '0;
  localparam int NDIR = 23;
  localparam int RAND_PER_PHASE = 334;
  localparam int GAP_PCT [3] = '{33, 55, 0};
  localparam int STALL_PCT [3] = '{55, 33, 0};

  // byte, typed, count, first token, second token
  localparam byte_step_t DIR_TAB [NDIR] = '{
    {CH_COMMA,  1'b1, 2'd1, {KIND_FIELD, 8'h00, 1'b1}, NO_RES},
    {CH_QUOTE,  1'b1, 2'd0, NO_RES, NO_RES},
    {8'h61,     1'b0, 2'd0, NO_RES, NO_RES},
    {CH_COMMA,  1'b0, 2'd0, NO_RES, NO_RES},
    {CH_QUOTE,  1'b0, 2'd0, NO_RES, NO_RES},
    {CH_QUOTE,  1'b0, 2'd0, NO_RES, NO_RES},
    {CH_QUOTE,  1'b0, 2'd0, NO_RES, NO_RES},
    {CH_COMMA,  1'b0, 2'd0, NO_RES, NO_RES},
    {8'h00,     1'b1, 2'd1, {KIND_DATA, 8'h00, 1'b1}, NO_RES},
    {8'hFF,     1'b1, 2'd1, {KIND_DATA, 8'hFF, 1'b1}, NO_RES},
    {CH_APOS,   1'b1, 2'd2, {KIND_DATA, CH_BSLASH, 1'b0}, {KIND_DATA, CH_APOS, 1'b1}},
    {CH_BSLASH, 1'b1, 2'd2, {KIND_DATA, CH_BSLASH, 1'b0}, {KIND_DATA, CH_BSLASH, 1'b1}},
    {CH_QUOTE,  1'b0, 2'd0, NO_RES, NO_RES},
    {CH_CR,     1'b1, 2'd1, {KIND_ROW, 8'h00, 1'b1}, NO_RES},
    {CH_LF,     1'b1, 2'd0, NO_RES, NO_RES},
    {CH_CR,     1'b1, 2'd0, NO_RES, NO_RES},
    {CH_QUOTE,  1'b0, 2'd0, NO_RES, NO_RES},
    {8'h62,     1'b0, 2'd0, NO_RES, NO_RES},
    {CH_LF,     1'b0, 2'd0, NO_RES, NO_RES},
    {CH_QUOTE,  1'b0, 2'd0, NO_RES, NO_RES},
    {CH_COMMA,  1'b0, 2'd0, NO_RES, NO_RES},
    {8'h80,     1'b0, 2'd0, NO_RES, NO_RES},
    {CH_LF,     1'b0, 2'd0, NO_RES, NO_RES}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_value;
  logic       out_last;

  logic [1:0] tk_cls;
  logic       tk_parity;
  logic       tk_quoting;
  logic       tk_empty;

  res_t       token_q [$];
  logic [7:0] csv_text [$];
  int         gap_pct = 0;
  int         stall_pct = 0;
  int         errors = 0;
  int         n_bytes = 0;
  int         n_tokens = 0;
  int         n_rows = 0;

  csv_byte_tokenizer_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .out_value (out_value),
    .out_last  (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d tokens still pending", token_q.size());
    $display("== FAIL ==");
    $finish;
  end

  function automatic void tokenize(input logic [7:0] c, output int n,
                                   output res_t r0, output res_t r1);
    n = 0;
    r0 = NO_RES;
    r1 = NO_RES;
    if (c == CH_COMMA) begin
      if (tk_parity && tk_quoting) begin
        r0 = {KIND_DATA, c, 1'b1};
        tk_empty = 1'b0;
      end else begin
        tk_quoting = 1'b0;
        tk_parity = 1'b0;
        tk_empty = 1'b1;
        r0 = {KIND_FIELD, 8'h00, 1'b1};
      end
      n = 1;
      tk_cls = CLS_COMMA;
    end else if (c == CH_QUOTE) begin
      if (!tk_quoting && (tk_empty || tk_cls == CLS_COMMA)) begin
        tk_parity = ~tk_parity;
        tk_quoting = 1'b1;
      end else if (tk_cls == CLS_QUOTE && !tk_parity) begin
        tk_parity = 1'b1;
        tk_empty = 1'b0;
        r0 = {KIND_DATA, c, 1'b1};
        n = 1;
      end else begin
        tk_parity = ~tk_parity;
      end
      tk_cls = CLS_QUOTE;
    end else if (c == CH_LF || c == CH_CR) begin
      // a CR/LF run closes the row once
      if (tk_cls != CLS_NEWLINE) begin
        tk_parity = 1'b0;
        tk_empty = 1'b1;
        tk_cls = CLS_NEWLINE;
        r0 = {KIND_ROW, 8'h00, 1'b1};
        n = 1;
      end
    end else begin
      if (c == CH_APOS || c == CH_BSLASH) begin
        r0 = {KIND_DATA, CH_BSLASH, 1'b0};
        r1 = {KIND_DATA, c, 1'b1};
        n = 2;
      end else begin
        r0 = {KIND_DATA, c, 1'b1};
        n = 1;
      end
      tk_empty = 1'b0;
      tk_cls = CLS_OTHER;
    end
  endfunction

  function automatic logic [7:0] field_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return CH_APOS;
    if (r < 12) return CH_BSLASH;
    if (r < 22) return 8'($urandom_range(0, 255));
    if (r < 40) return 8'($urandom_range(8'h30, 8'h39));
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 6))
      0: return CH_COMMA;
      1: return CH_QUOTE;
      2: return CH_CR;
      3: return CH_LF;
      4: return CH_APOS;
      5: return CH_BSLASH;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_char(input logic [7:0] c);
    csv_text = {csv_text, c};
  endfunction

  function automatic void add_row();
    int  nf;
    int  len;
    bit  quoted;
    nf = $urandom_range(1, 4);
    for (int f = 0; f < nf; f++) begin
      if (f != 0) add_char(CH_COMMA);
      quoted = ($urandom_range(0, 2) == 0);
      if (quoted) add_char(CH_QUOTE);
      len = $urandom_range(0, 6);
      for (int i = 0; i < len; i++) begin
        if (quoted && $urandom_range(0, 9) == 0) begin
          add_char(CH_QUOTE);
          add_char(CH_QUOTE);
        end else if (quoted && $urandom_range(0, 9) == 0) begin
          add_char(CH_COMMA);
        end else begin
          add_char(field_char());
        end
      end
      if (quoted) add_char(CH_QUOTE);
    end
    case ($urandom_range(0, 3))
      0: add_char(CH_LF);
      1: add_char(CH_CR);
      2: begin
        add_char(CH_CR);
        add_char(CH_LF);
      end
      default: begin
        add_char(CH_CR);
        add_char(CH_LF);
        add_char(CH_CR);
        add_char(CH_LF);
      end
    endcase
  endfunction

  // called at a rising edge; returns at the edge of the transfer
  task automatic send_byte(input byte_step_t row);
    int   n;
    res_t p0;
    res_t p1;
    bit   ok;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= row.b;
    do begin
      @(negedge clk);
      ok = (in_stall === 1'b0);
      @(posedge clk);
    end while (!ok);
    n_bytes++;
    tokenize(row.b, n, p0, p1);
    if (row.typed) begin
      n = int'(row.n);
      p0 = row.r0;
      p1 = row.r1;
    end
    if (n > 0) token_q = {token_q, p0};
    if (n > 1) token_q = {token_q, p1};
  endtask

  task automatic note_error(input string what, input res_t want, input res_t got);
    if (errors < 10) begin
      $display("%0t %s: expected kind %0d value %h last %b, got kind %0d value %h last %b",
               $time, what, want.kind, want.value, want.last, got.kind, got.value, got.last);
    end
    errors++;
  endtask

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
  end

  always @(negedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = {out_kind, out_value, out_last};
      n_tokens++;
      if (got.kind == KIND_ROW) n_rows++;
      if (token_q.size() == 0) begin
        note_error("unexpected token", NO_RES, got);
      end else begin
        want = token_q.pop_front();
        if (got.kind !== want.kind || got.value !== want.value || got.last !== want.last) begin
          note_error("token mismatch", want, got);
        end
      end
    end
  end

  initial begin
    tk_cls = CLS_NEWLINE;
    tk_parity = 1'b0;
    tk_quoting = 1'b0;
    tk_empty = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gap_pct = GAP_PCT[0];
    stall_pct = STALL_PCT[0];
    for (int i = 0; i < NDIR; i++) send_byte(DIR_TAB[i]);
    for (int p = 0; p < 3; p++) begin
      gap_pct = GAP_PCT[p];
      stall_pct = STALL_PCT[p];
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        if (csv_text.size() == 0) begin
          if ($urandom_range(0, 4) != 0) begin
            add_row();
          end else begin
            for (int j = $urandom_range(1, 12); j > 0; j--) add_char(noise_char());
          end
        end
        send_byte({csv_text.pop_front(), 1'b0, 2'd0, NO_RES, NO_RES});
      end
    end
    in_valid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Fed %0d bytes (%0d from the directed table) through three idling mixes;",
             n_bytes, NDIR);
    $display("checked %0d tokens including %0d row ends, %0d errors.", n_tokens, n_rows, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
